[rtl/imce_pkg.sv]
package imce_pkg;

  // frame geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int EW_W        = $clog2(MAX_WIDTH + 1);
  localparam int EH_W        = $clog2(MAX_HEIGHT + 1);
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;

  // pixel and register widths
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int CFG_W     = 9;
  localparam int MODE_W    = 3;
  localparam int REG_IDX_W = 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd2;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_RED    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GREEN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BLUE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_GREY   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLIP_H = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FLIP_V = 3'd5;

  // reset values of the registers
  localparam logic [CFG_W-1:0]  WIDTH_RST  = 9'd256;
  localparam logic [CFG_W-1:0]  HEIGHT_RST = 9'd256;
  localparam logic [MODE_W-1:0] MODE_RST   = MODE_GREY;

  // divide by 3 as multiply by reciprocal, exact for sums up to 765
  localparam int SUM_W    = CH_W + 2;
  localparam int DIV3_SH  = 11;
  localparam logic [DIV3_SH-1:0] DIV3_MUL = 11'd683;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pixel_t;

endpackage

[rtl/image_mirror_and_channel_engine.sv]
// Frame engine with mirror and channel filter modes.
// Input channel (in_valid/in_ready): kind 0 loads one pixel into the frame
// store in raster order; loads past the end of the frame are dropped.
// kind 1 pulls the next output pixel, read from the mirrored address in the
// flip modes, else filtered to one channel, averaged to grey or passed as is.
// Output channel (out_valid/out_ready): one transaction per pull, none per
// load. A pull before the frame is complete returns valid_res 0 with all
// other fields 0. last marks the final pixel, after which every counter
// rewinds and a new frame must be loaded.
// Sequencing: loads can follow back to back while the block is idle. A pull
// passes from idle through the read state to the output state, and back to
// idle once the receiver is ready: frame store read, format, then the output
// register; an early pull skips the read state. One transaction is in flight
// at a time, set by the sequencer, which accepts input only while idle.
// Configuration: cfg_we writes register cfg_index; writing width or height
// rewinds the counters. The user makes writes only while the block is idle;
// the block does not enforce this. Reset (rst, synchronous) rewinds the
// counters and restores 256 x 256 grey mode. The frame store is not cleared.
// While stalled, the result holds in the output register; no input is accepted.
module image_mirror_and_channel_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [imce_pkg::CH_W-1:0]      red_in,
  input  logic [imce_pkg::CH_W-1:0]      green_in,
  input  logic [imce_pkg::CH_W-1:0]      blue_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [imce_pkg::CH_W-1:0]      red_out,
  output logic [imce_pkg::CH_W-1:0]      green_out,
  output logic [imce_pkg::CH_W-1:0]      blue_out,
  output logic                           valid_res,
  output logic                           last,
  input  logic                           cfg_we,
  input  logic [imce_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [imce_pkg::CFG_W-1:0]     cfg_data
);
  import imce_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0]   frame_width;
  logic [CFG_W-1:0]   frame_height;
  logic [MODE_W-1:0]  mode;
  logic [COUNT_W-1:0] loaded_count;
  logic [COL_W-1:0]   read_column;
  logic [ROW_W-1:0]   read_row;
  logic               fin_q;

  logic [EW_W-1:0]       w_eff;
  logic [EH_W-1:0]       h_eff;
  logic [COL_W-1:0]      w_last;
  logic [ROW_W-1:0]      h_last;
  logic [COUNT_W-1:0]    total;
  logic                  full;
  logic [COL_W-1:0]      col_c;
  logic [ROW_W-1:0]      row_c;
  logic [COL_W-1:0]      col_sel;
  logic [ROW_W-1:0]      row_sel;
  logic [ROW_W+EW_W-1:0] row_base;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  fin;

  logic   accept, load, pull, store_we, store_re, dim_write;
  pixel_t store_rdata;
  pixel_t fmt_pix;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign accept    = in_valid && in_ready;
  assign load      = accept && !kind;
  assign pull      = accept && kind;
  assign dim_write = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  // effective dimensions: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (frame_width == '0) begin
      w_eff = EW_W'(1);
    end else if (frame_width > CFG_W'(MAX_WIDTH)) begin
      w_eff = EW_W'(MAX_WIDTH);
    end else begin
      w_eff = EW_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = EH_W'(1);
    end else if (frame_height > CFG_W'(MAX_HEIGHT)) begin
      h_eff = EH_W'(MAX_HEIGHT);
    end else begin
      h_eff = EH_W'(frame_height);
    end
    w_last = COL_W'(w_eff - EW_W'(1));
    h_last = ROW_W'(h_eff - EH_W'(1));
    total  = COUNT_W'(COUNT_W'(w_eff) * COUNT_W'(h_eff));
    full   = (loaded_count >= total);
  end

  // read address, mirrored in the flip modes
  always_comb begin
    col_c    = (read_column > w_last) ? w_last : read_column;
    row_c    = (read_row > h_last) ? h_last : read_row;
    col_sel  = (mode == MODE_FLIP_H) ? (w_last - col_c) : col_c;
    row_sel  = (mode == MODE_FLIP_V) ? (h_last - row_c) : row_c;
    row_base = (ROW_W+EW_W)'(row_sel) * (ROW_W+EW_W)'(w_eff);
    rd_addr  = ADDR_W'(row_base + (ROW_W+EW_W)'(col_sel));
    fin      = (col_c == w_last) && (row_c == h_last);
  end

  assign store_we = load && !full;
  assign store_re = pull && full;

  imce_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(loaded_count[ADDR_W-1:0]),
    .wdata({red_in, green_in, blue_in}),
    .re   (store_re),
    .raddr(rd_addr),
    .rdata(store_rdata)
  );

  imce_fmt u_fmt (
    .pix (store_rdata),
    .mode(mode),
    .res (fmt_pix)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pull) begin
          state_next = full ? S_READ : S_OUT;
        end
      end
      S_READ: state_next = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
      mode         <= MODE_RST;
      loaded_count <= '0;
      read_column  <= '0;
      read_row     <= '0;
    end else begin
      if (store_we) begin
        loaded_count <= loaded_count + COUNT_W'(1);
      end
      if (store_re) begin
        if (fin) begin
          loaded_count <= '0;
          read_column  <= '0;
          read_row     <= '0;
        end else if (col_c == w_last) begin
          read_column <= '0;
          read_row    <= row_c + ROW_W'(1);
        end else begin
          read_column <= col_c + COL_W'(1);
          read_row    <= row_c;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  frame_width  <= cfg_data;
          REG_HEIGHT: frame_height <= cfg_data;
          REG_MODE:   mode         <= cfg_data[MODE_W-1:0];
          default:    ;
        endcase
      end
      if (dim_write) begin
        loaded_count <= '0;
        read_column  <= '0;
        read_row     <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (store_re) begin
      fin_q <= fin;
    end
    if (pull && !full) begin
      red_out   <= '0;
      green_out <= '0;
      blue_out  <= '0;
      valid_res <= 1'b0;
      last      <= 1'b0;
    end else if (state == S_READ) begin
      red_out   <= fmt_pix.r;
      green_out <= fmt_pix.g;
      blue_out  <= fmt_pix.b;
      valid_res <= 1'b1;
      last      <= fin_q;
    end
  end

endmodule

[rtl/imce_ram.sv]
module imce_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/imce_fmt.sv]
module imce_fmt (
  input  imce_pkg::pixel_t            pix,
  input  logic [imce_pkg::MODE_W-1:0] mode,
  output imce_pkg::pixel_t            res
);
  import imce_pkg::*;

  logic [SUM_W-1:0]         sum;
  logic [SUM_W+DIV3_SH-1:0] prod;
  logic [CH_W-1:0]          grey;

  // channel average, truncated
  always_comb begin
    sum  = SUM_W'(pix.r) + SUM_W'(pix.g) + SUM_W'(pix.b);
    prod = (SUM_W+DIV3_SH)'(sum) * (SUM_W+DIV3_SH)'(DIV3_MUL);
    grey = CH_W'(prod >> DIV3_SH);
  end

  // channel filter, grey average or pass-through
  always_comb begin
    res = pix;
    unique case (mode)
      MODE_RED: begin
        res.g = '0;
        res.b = '0;
      end
      MODE_GREEN: begin
        res.r = '0;
        res.b = '0;
      end
      MODE_BLUE: begin
        res.r = '0;
        res.g = '0;
      end
      MODE_GREY: begin
        res.r = grey;
        res.g = grey;
        res.b = grey;
      end
      default: res = pix;
    endcase
  end

endmodule

[rtl/imce_checker.sv]
module imce_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [imce_pkg::CH_W-1:0] red_out,
  input logic [imce_pkg::CH_W-1:0] green_out,
  input logic [imce_pkg::CH_W-1:0] blue_out,
  input logic                      valid_res,
  input logic                      last
);
  import imce_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({red_out, green_out, blue_out,
                                                      valid_res, last}))
    else $error("output transaction changed while stalled");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // an early pull carries an all-zero pixel
  a_early_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> red_out == '0 && green_out == '0 && blue_out == '0
                                && !last)
    else $error("early pull returned nonzero fields");

  // one transaction in flight: no input accepted while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

endmodule

bind image_mirror_and_channel_engine imce_checker u_imce_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .red_out  (red_out),
  .green_out(green_out),
  .blue_out (blue_out),
  .valid_res(valid_res),
  .last     (last)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import imce_pkg::*;

  // transaction kinds on the input channel
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_PULL = 1'b1;

  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1200;

  typedef struct packed {
    logic   kind;
    pixel_t pix;
  } feed_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            shown;
    logic            fin;
  } pix_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 kind      = KIND_LOAD;
  logic [CH_W-1:0]      red_in    = '0;
  logic [CH_W-1:0]      green_in  = '0;
  logic [CH_W-1:0]      blue_in   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CH_W-1:0]      red_out;
  logic [CH_W-1:0]      green_out;
  logic [CH_W-1:0]      blue_out;
  logic                 valid_res;
  logic                 last;
  logic                 cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = '0;

  image_mirror_and_channel_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .valid_res (valid_res),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // pending pixels to send and pixels the engine still owes us
  feed_item_t  feed_q[$];
  pix_result_t expected_q[$];
  int unsigned stim_count = 0;
  int unsigned bad_count  = 0;

  // shadow copy of the engine state
  logic [PIX_W-1:0]  shadow_store [STORE_DEPTH];
  int unsigned       fill_count;
  int unsigned       pull_col;
  int unsigned       pull_row;
  logic [CFG_W-1:0]  width_reg;
  logic [CFG_W-1:0]  height_reg;
  logic [MODE_W-1:0] mode_reg;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void rewind_reader();
    fill_count = 0;
    pull_col   = 0;
    pull_row   = 0;
  endfunction

  // returns 1 when the transaction produces an output pixel
  function automatic bit predict_pixel(input logic k, input pixel_t p,
                                       output pix_result_t res);
    int unsigned w, h, total, col, row, addr, sum;
    pixel_t px;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    total = w * h;
    res = '0;
    if (k == KIND_LOAD) begin
      // loads past the end of the frame are dropped
      if (fill_count < total) begin
        shadow_store[fill_count] = p;
        fill_count++;
      end
      return 1'b0;
    end
    // pull before the frame is complete
    if (fill_count < total) return 1'b1;

    col = (pull_col >= w) ? w - 1 : pull_col;
    row = (pull_row >= h) ? h - 1 : pull_row;
    case (mode_reg)
      MODE_FLIP_H: addr = row * w + (w - 1 - col);
      MODE_FLIP_V: addr = (h - 1 - row) * w + col;
      default:     addr = row * w + col;
    endcase
    px = shadow_store[addr];

    case (mode_reg)
      MODE_RED:   begin px.g = '0; px.b = '0; end
      MODE_GREEN: begin px.r = '0; px.b = '0; end
      MODE_BLUE:  begin px.r = '0; px.g = '0; end
      MODE_GREY: begin
        sum  = px.r + px.g + px.b;
        px.r = CH_W'(sum / 3);
        px.g = px.r;
        px.b = px.r;
      end
      default: ;
    endcase

    // advance the raster position, rewind after the final pixel
    res.fin = (col == w - 1) && (row == h - 1);
    if (res.fin) begin
      rewind_reader();
    end else if (col == w - 1) begin
      pull_col = 0;
      pull_row = row + 1;
    end else begin
      pull_col = col + 1;
      pull_row = row;
    end
    res.red   = px.r;
    res.green = px.g;
    res.blue  = px.b;
    res.shown = 1'b1;
    return 1'b1;
  endfunction

  // track register writes and accepted input transactions
  pix_result_t next_res;

  always @(posedge clk) begin
    if (rst) begin
      rewind_reader();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      mode_reg   = MODE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH: begin
            width_reg = cfg_data;
            rewind_reader();
          end
          REG_HEIGHT: begin
            height_reg = cfg_data;
            rewind_reader();
          end
          REG_MODE: mode_reg = cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (predict_pixel(kind, {red_in, green_in, blue_in}, next_res))
          expected_q.push_back(next_res);
      end
    end
  end

  // sender: bursts of random length separated by random gaps
  feed_item_t  send_item;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        send_item = feed_q.pop_front();
        kind     <= send_item.kind;
        red_in   <= send_item.pix.r;
        green_in <= send_item.pix.g;
        blue_in  <= send_item.pix.b;
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: ready runs and stall runs of its own lengths
  int unsigned rdy_left   = 0;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      rdy_left   = 0;
      stall_left = 0;
    end else if (rdy_left > 0) begin
      rdy_left--;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      rdy_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
      stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      out_ready  <= 1'b1;
    end
  end

  // compare each output transaction with the oldest expected pixel
  pix_result_t got_res;
  pix_result_t want_res;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_res = '{red_out, green_out, blue_out, valid_res, last};
      if (expected_q.size() == 0) begin
        if (bad_count < 10)
          $display("unexpected output: r=%0d g=%0d b=%0d valid_res=%0d last=%0d",
                   got_res.red, got_res.green, got_res.blue, got_res.shown,
                   got_res.fin);
        bad_count++;
      end else begin
        want_res = expected_q.pop_front();
        if (got_res !== want_res) begin
          if (bad_count < 10)
            $display({"mismatch: expected r=%0d g=%0d b=%0d valid_res=%0d last=%0d",
                      " got r=%0d g=%0d b=%0d valid_res=%0d last=%0d"},
                     want_res.red, want_res.green, want_res.blue, want_res.shown,
                     want_res.fin, got_res.red, got_res.green, got_res.blue,
                     got_res.shown, got_res.fin);
          bad_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    return {rand_channel(), rand_channel(), rand_channel()};
  endfunction

  task automatic push_item(input logic k, input pixel_t p, input bit counted);
    feed_q.push_back('{kind: k, pix: p});
    if (counted) stim_count++;
  endtask

  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // wait until every transaction is sent and answered, then let the pipe drain
  task automatic settle();
    do @(negedge clk);
    while (feed_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // frame too large to finish: a few loads then a pull that must come back empty
  task automatic partial_frame(input logic [CFG_W-1:0] wv, hv, input int unsigned n);
    set_reg(REG_WIDTH, wv);
    set_reg(REG_HEIGHT, hv);
    repeat (n) push_item(KIND_LOAD, rand_pixel(), 1'b1);
    push_item(KIND_PULL, rand_pixel(), 1'b1);
    settle();
  endtask

  // one frame: load, read back, with noise and broken sequences unless tidy
  task automatic run_frame(input logic [CFG_W-1:0] wv, hv,
                           input logic [MODE_W-1:0] mv, input bit tidy);
    int unsigned total, cut;
    total = clamp_dim(wv, MAX_WIDTH) * clamp_dim(hv, MAX_HEIGHT);
    set_reg(REG_WIDTH, wv);
    set_reg(REG_HEIGHT, hv);
    set_reg(REG_MODE, {6'($urandom), mv});

    // load abandoned part way, the next size write rewinds it
    if (!tidy && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, total - 1);
      repeat (cut) push_item(KIND_LOAD, rand_pixel(), 1'b1);
      push_item(KIND_PULL, rand_pixel(), 1'b1);
      settle();
      return;
    end

    // loads with the odd early pull mixed in
    repeat (total) begin
      if (!tidy && $urandom_range(0, 7) == 0)
        push_item(KIND_PULL, rand_pixel(), 1'b1);
      push_item(KIND_LOAD, rand_pixel(), 1'b1);
    end
    if (!tidy && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) push_item(KIND_LOAD, rand_pixel(), 1'b0);

    // read out, possibly changing the mode part way through
    cut = tidy ? total : $urandom_range(0, total);
    repeat (cut) push_item(KIND_PULL, rand_pixel(), 1'b1);
    settle();
    if (cut < total) begin
      if ($urandom_range(0, 5) == 0) return;
      set_reg(REG_MODE, {6'($urandom), MODE_W'($urandom_range(0, 7))});
      repeat (total - cut) push_item(KIND_PULL, rand_pixel(), 1'b1);
      settle();
    end

    // pull after the rewind comes back empty
    if (!tidy && $urandom_range(0, 3) == 0) begin
      push_item(KIND_PULL, rand_pixel(), 1'b1);
      settle();
    end
  endtask

  initial begin
    int unsigned      target;
    int unsigned      n;
    int unsigned      sel;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    logic [MODE_W-1:0] mv;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // pull straight after reset, nothing loaded
    push_item(KIND_PULL, '0, 1'b1);
    settle();

    // zero sizes act as a 1 x 1 frame, extra load dropped, grey of full white
    set_reg(REG_WIDTH, '0);
    set_reg(REG_HEIGHT, '0);
    push_item(KIND_LOAD, {8'hFF, 8'hFF, 8'hFF}, 1'b1);
    push_item(KIND_LOAD, {8'h00, 8'h00, 8'h00}, 1'b0);
    push_item(KIND_PULL, '0, 1'b1);
    push_item(KIND_PULL, '1, 1'b1);
    settle();

    // 3 x 2 frame mirrored horizontally, then vertically half way through
    set_reg(REG_WIDTH, 9'd3);
    set_reg(REG_HEIGHT, 9'd2);
    set_reg(REG_MODE, MODE_FLIP_H);
    push_item(KIND_LOAD, {8'hFF, 8'h00, 8'h00}, 1'b1);
    push_item(KIND_LOAD, {8'h00, 8'hFF, 8'h00}, 1'b1);
    push_item(KIND_LOAD, {8'h00, 8'h00, 8'hFF}, 1'b1);
    push_item(KIND_PULL, '0, 1'b1);
    push_item(KIND_LOAD, {8'h00, 8'h00, 8'h00}, 1'b1);
    push_item(KIND_LOAD, {8'hFF, 8'hFF, 8'hFF}, 1'b1);
    push_item(KIND_LOAD, {8'h80, 8'h7F, 8'h01}, 1'b1);
    repeat (3) push_item(KIND_PULL, '0, 1'b1);
    settle();
    set_reg(REG_MODE, MODE_FLIP_V);
    repeat (3) push_item(KIND_PULL, '0, 1'b1);
    settle();

    target = stim_count + RANDOM_ITEMS;

    // widest frame with an oversized width, and oversized or maximum sizes
    run_frame('1, '0, MODE_FLIP_H, 1'b1);
    partial_frame('0, '1, 20);
    partial_frame(9'd256, 9'd256, 25);

    // random frames, mostly small, now and then one of extreme width or height
    n = 0;
    while (stim_count < target) begin
      sel = $urandom_range(0, 24);
      if (sel == 0) begin
        wv = CFG_W'($urandom_range(0, 511));
        hv = CFG_W'($urandom_range(0, 1));
      end else if (sel == 1) begin
        wv = CFG_W'($urandom_range(0, 1));
        hv = CFG_W'($urandom_range(0, 511));
      end else begin
        wv = CFG_W'($urandom_range(1, 7));
        hv = CFG_W'($urandom_range(1, 7));
      end
      mv = (n < 8) ? MODE_W'(n) : MODE_W'($urandom_range(0, 7));
      run_frame(wv, hv, mv, 1'b0);
      n++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
